FILE: src/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/ntd_pkg.sv
package ntd_pkg;

  localparam int TABLE_ENTRIES = 512;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int CONSUMED_BITS = 24;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EARLY   = 2'd1;
  localparam logic [1:0] STATUS_BADCODE = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]               out_byte;
    logic                     byte_valid;
    logic                     last;
    logic [1:0]               status;
    logic [CONSUMED_BITS-1:0] consumed_bytes;
  } out_item_t;

endpackage

FILE: src/ntd_ram.sv
module ntd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/nemesis_tile_decompressor_top.sv
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid/in_ready   | in_data  : stream byte, start mark, end mark
// out     | out | out_valid/out_ready | out_data : tile byte or status beat
//
// Header and table bytes go from IDLE through FIN. A bitstream byte shifts its bits
// out in BIT, with one code table read (registered RAM port) in LOOK per looked-up
// bit, and ends in FIN; each emitted run is written out nibble by nibble in RUN.
// Reset and every start_of_stream beat launch a clearing pass over all 512 table
// entries; no input beat is taken during it. A stalled out channel holds the run
// engine, which in turn holds the input.
module nemesis_tile_decompressor_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ntd_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ntd_pkg::out_item_t out_data
);
  import ntd_pkg::*;

  // stream phase
  localparam logic [2:0] PH_HDR_HI = 3'd0;
  localparam logic [2:0] PH_HDR_LO = 3'd1;
  localparam logic [2:0] PH_TABLE  = 3'd2;
  localparam logic [2:0] PH_BITS   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // sequencer
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BIT  = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        xor_r, xor_nxt;
  logic [14:0] tile_r, tile_nxt;
  logic [20:0] total_r, total_nxt;       // tile count * 64 nibbles
  logic [20:0] nw_r, nw_nxt;             // nibbles written
  logic [3:0]  grp_r, grp_nxt;
  logic [7:0]  pend_r, pend_nxt;         // pending descriptor, 0 = none
  logic [7:0]  acc_r, acc_nxt;
  logic [3:0]  len_r, len_nxt;
  logic        lit_r, lit_nxt;
  logic [2:0]  lbits_r, lbits_nxt;
  logic [6:0]  lval_r, lval_nxt;
  logic        half_v_r, half_v_nxt;
  logic [3:0]  half_n_r, half_n_nxt;
  logic [31:0] prow_r, prow_nxt;
  logic [4:0]  tidx_r, tidx_nxt;
  logic [CONSUMED_BITS-1:0] cons_r, cons_nxt;
  logic [7:0]  sh_r, sh_nxt;             // bitstream shift register, MSB first
  logic [3:0]  bcnt_r, bcnt_nxt;
  logic        eod_r, eod_nxt;
  logic [3:0]  run_nib_r, run_nib_nxt;
  logic [3:0]  run_cnt_r, run_cnt_nxt;

  // table clearing pass
  logic              clr_r, clr_nxt;
  logic [TBL_AW-1:0] clr_addr_r, clr_addr_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // table RAM
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr, ram_waddr, ram_raddr;
  logic [7:0]        tbl_wdata, ram_wdata, ram_rdata;
  logic              ram_we;

  logic       accept, slot_free, emit, bit_in;
  out_item_t  emit_data;
  logic [2:0] ph;
  logic [7:0] b, obyte, tcode;
  logic [3:0] dlen;
  logic [14:0] tile_lo;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE) && !clr_r;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ram_we    = clr_r || tbl_we;
  assign ram_waddr = clr_r ? clr_addr_r : tbl_waddr;
  assign ram_wdata = clr_r ? 8'h00 : tbl_wdata;

  ntd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;   phase_nxt  = phase_r;   xor_nxt   = xor_r;
    tile_nxt    = tile_r;    total_nxt  = total_r;   nw_nxt    = nw_r;
    grp_nxt     = grp_r;     pend_nxt   = pend_r;    acc_nxt   = acc_r;
    len_nxt     = len_r;     lit_nxt    = lit_r;     lbits_nxt = lbits_r;
    lval_nxt    = lval_r;    half_v_nxt = half_v_r;  half_n_nxt = half_n_r;
    prow_nxt    = prow_r;    tidx_nxt   = tidx_r;    cons_nxt  = cons_r;
    sh_nxt      = sh_r;      bcnt_nxt   = bcnt_r;    eod_nxt   = eod_r;
    run_nib_nxt = run_nib_r; run_cnt_nxt = run_cnt_r;
    clr_nxt     = clr_r;     clr_addr_nxt = clr_addr_r;
    tbl_we      = 1'b0;
    tbl_waddr   = '0;
    tbl_wdata   = 8'h00;
    ram_raddr   = '0;
    emit        = 1'b0;
    emit_data   = '0;
    b           = in_data.in_byte;
    ph          = phase_r;
    bit_in      = sh_r[7];
    obyte       = 8'h00;
    dlen        = 4'd0;
    tcode       = 8'h00;
    tile_lo     = 15'd0;

    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == {TBL_AW{1'b1}}) begin
        clr_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.start_of_stream) begin
            ph = PH_HDR_HI;
            phase_nxt = PH_HDR_HI; xor_nxt = 1'b0; tile_nxt = '0; total_nxt = '0;
            nw_nxt = '0; grp_nxt = '0; pend_nxt = '0; acc_nxt = '0; len_nxt = '0;
            lit_nxt = 1'b0; lbits_nxt = '0; lval_nxt = '0; half_v_nxt = 1'b0;
            half_n_nxt = '0; prow_nxt = '0; tidx_nxt = '0; cons_nxt = '0;
            clr_nxt = 1'b1; clr_addr_nxt = '0;
          end
          if (ph != PH_DONE) begin
            if ((in_data.start_of_stream ? '0 : cons_r) != {CONSUMED_BITS{1'b1}}) begin
              cons_nxt = (in_data.start_of_stream ? '0 : cons_r) + 1'b1;
            end
            eod_nxt   = in_data.end_of_data;
            state_nxt = ST_FIN;
            case (ph)
              PH_HDR_HI: begin
                xor_nxt   = b[7];
                tile_nxt  = {b[6:0], 8'h00};
                phase_nxt = PH_HDR_LO;
              end
              PH_HDR_LO: begin
                tile_lo = {tile_r[14:8], b};
                if (tile_lo == 15'd0) begin
                  tile_lo = 15'd256;
                end
                tile_nxt  = tile_lo;
                total_nxt = {tile_lo, 6'd0};
                phase_nxt = PH_TABLE;
              end
              PH_TABLE: begin
                if (pend_r != 8'h00) begin
                  dlen      = pend_r[3:0];
                  tcode     = b >> (4'd8 - dlen);
                  tbl_we    = 1'b1;
                  tbl_waddr = (TBL_AW'(1) << dlen) | TBL_AW'(tcode);
                  tbl_wdata = {1'b1, pend_r[6:4], grp_r};
                  pend_nxt  = 8'h00;
                end else if (b == 8'hFF) begin
                  phase_nxt = PH_BITS;
                end else if (b[7]) begin
                  grp_nxt = b[3:0];
                end else if (b[3:0] == 4'd0 || b[3:0] > 4'd8) begin
                  phase_nxt = PH_BITS;
                end else begin
                  pend_nxt = b;
                end
              end
              default: begin
                sh_nxt    = b;
                bcnt_nxt  = 4'd8;
                state_nxt = ST_BIT;
              end
            endcase
          end
        end
      end

      ST_BIT: begin
        if (phase_r != PH_BITS || bcnt_r == 4'd0) begin
          state_nxt = ST_FIN;
        end else begin
          sh_nxt   = {sh_r[6:0], 1'b0};
          bcnt_nxt = bcnt_r - 1'b1;
          if (lit_r) begin
            lval_nxt  = {lval_r[5:0], bit_in};
            lbits_nxt = lbits_r + 1'b1;
            if (lbits_r == 3'd6) begin
              lit_nxt     = 1'b0;
              lbits_nxt   = '0;
              lval_nxt    = '0;
              run_nib_nxt = {lval_r[2:0], bit_in};
              run_cnt_nxt = {1'b0, lval_r[5:3]} + 4'd1;
              state_nxt   = ST_RUN;
            end
          end else begin
            acc_nxt = {acc_r[6:0], bit_in};
            len_nxt = len_r + 1'b1;
            if (len_r == 4'd5 && {acc_r[6:0], bit_in} == 8'h3F) begin
              lit_nxt   = 1'b1;
              lbits_nxt = '0;
              lval_nxt  = '0;
              acc_nxt   = '0;
              len_nxt   = '0;
            end else begin
              ram_raddr = (TBL_AW'(1) << (len_r + 4'd1)) | TBL_AW'({acc_r[6:0], bit_in});
              state_nxt = ST_LOOK;
            end
          end
        end
      end

      ST_LOOK: begin
        if (ram_rdata[7]) begin
          acc_nxt     = '0;
          len_nxt     = '0;
          run_nib_nxt = ram_rdata[3:0];
          run_cnt_nxt = {1'b0, ram_rdata[6:4]} + 4'd1;
          state_nxt   = ST_RUN;
        end else if (len_r >= 4'd8) begin
          phase_nxt = PH_DONE;
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_BIT;
        end
      end

      ST_RUN: begin
        if (run_cnt_r == 4'd0 || phase_r != PH_BITS || nw_r >= total_r) begin
          state_nxt = ST_BIT;
        end else if (!half_v_r) begin
          half_v_nxt  = 1'b1;
          half_n_nxt  = run_nib_r;
          nw_nxt      = nw_r + 1'b1;
          run_cnt_nxt = run_cnt_r - 1'b1;
        end else if (slot_free) begin
          obyte = {half_n_r, run_nib_r};
          if (xor_r && tidx_r >= 5'd4) begin
            obyte = obyte ^ prow_r[31:24];
          end
          half_v_nxt  = 1'b0;
          nw_nxt      = nw_r + 1'b1;
          run_cnt_nxt = run_cnt_r - 1'b1;
          prow_nxt    = {prow_r[23:0], obyte};
          tidx_nxt    = tidx_r + 1'b1;
          emit        = 1'b1;
          emit_data.out_byte   = obyte;
          emit_data.byte_valid = 1'b1;
          emit_data.status     = STATUS_OK;
          if (nw_r + 21'd1 >= total_r) begin
            phase_nxt = PH_DONE;
            emit_data.last = 1'b1;
            emit_data.consumed_bytes = cons_r;
          end
        end
      end

      ST_ERR: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_data.last = 1'b1;
          emit_data.status = STATUS_BADCODE;
          emit_data.consumed_bytes = cons_r;
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (eod_r && phase_r != PH_DONE) begin
          if (slot_free) begin
            emit = 1'b1;
            emit_data.last = 1'b1;
            emit_data.status = STATUS_EARLY;
            emit_data.consumed_bytes = cons_r;
            phase_nxt = PH_DONE;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_ready);
    out_data_nxt  = emit ? emit_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;  phase_r <= PH_HDR_HI; xor_r <= 1'b0; tile_r <= '0;
      total_r <= '0;       nw_r <= '0;           grp_r <= '0;   pend_r <= '0;
      acc_r <= '0;         len_r <= '0;          lit_r <= 1'b0; lbits_r <= '0;
      lval_r <= '0;        half_v_r <= 1'b0;     half_n_r <= '0; prow_r <= '0;
      tidx_r <= '0;        cons_r <= '0;         bcnt_r <= '0;  eod_r <= 1'b0;
      run_cnt_r <= '0;     clr_r <= 1'b1;        clr_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  phase_r <= phase_nxt;   xor_r <= xor_nxt;
      tile_r <= tile_nxt;    total_r <= total_nxt;   nw_r <= nw_nxt;
      grp_r <= grp_nxt;      pend_r <= pend_nxt;     acc_r <= acc_nxt;
      len_r <= len_nxt;      lit_r <= lit_nxt;       lbits_r <= lbits_nxt;
      lval_r <= lval_nxt;    half_v_r <= half_v_nxt; half_n_r <= half_n_nxt;
      prow_r <= prow_nxt;    tidx_r <= tidx_nxt;     cons_r <= cons_nxt;
      bcnt_r <= bcnt_nxt;    eod_r <= eod_nxt;       run_cnt_r <= run_cnt_nxt;
      clr_r <= clr_nxt;      clr_addr_r <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    run_nib_r  <= run_nib_nxt;
    out_data_r <= out_data_nxt;
  end
endmodule

FILE: src/ntd_checker.sv
`include "assert_macros.svh"

module ntd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ntd_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ntd_pkg::out_item_t out_data
);
  import ntd_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  `ASSERT_IMPL(a_status_last, clk, rst_n, out_valid && !out_data.byte_valid, out_data.last)
  `ASSERT_IMPL(a_data_fields, clk, rst_n, out_valid && !out_data.last,
               out_data.consumed_bytes == '0 && out_data.status == STATUS_OK)
endmodule

bind nemesis_tile_decompressor_top ntd_checker u_ntd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
